FILE: hdl/m4bd_pkg.sv
// ----------------------------------------------------------------------------
// m4bd_pkg
// Shared widths, register indexes, result and configuration types and the
// clamping functions of the M4 / min-max bucket decimator.
// ----------------------------------------------------------------------------
package m4bd_pkg;

    // Frame and sample geometry
    localparam int MAX_FRAME     = 1048576;
    localparam int MAX_BUCKETS   = MAX_FRAME / 2;
    localparam int SAMPLE_BITS   = 16;
    localparam int INDEX_BITS    = $clog2(MAX_FRAME);
    localparam int LENGTH_BITS   = INDEX_BITS + 1;
    localparam int BUCKET_BITS   = INDEX_BITS;
    localparam int SCALED_BITS   = 2 * INDEX_BITS;

    // Result bundle: up to four indices per input sample
    localparam int MAX_RESULTS   = 4;
    localparam int SLOT_CNT_BITS = $clog2(MAX_RESULTS + 1);

    // Configuration port
    localparam int DATA_BITS      = 32;
    localparam int REG_INDEX_BITS = 2;
    localparam int ADDR_BITS      = REG_INDEX_BITS + 2;

    localparam logic [REG_INDEX_BITS-1:0] REG_MODE         = 2'd0;
    localparam logic [REG_INDEX_BITS-1:0] REG_FRAME_LENGTH = 2'd1;
    localparam logic [REG_INDEX_BITS-1:0] REG_BUCKET_COUNT = 2'd2;

    localparam logic                   MODE_MINMAX = 1'b0;
    localparam logic                   MODE_M4     = 1'b1;

    localparam logic [LENGTH_BITS-1:0] RESET_FRAME_LENGTH = LENGTH_BITS'(1024);
    localparam logic [BUCKET_BITS-1:0] RESET_BUCKET_COUNT = BUCKET_BITS'(64);

    // One emitted index with its markers
    typedef struct packed {
        logic [INDEX_BITS-1:0] index;
        logic                  bucket_end;
        logic                  frame_end;
    } result_t;

    // Effective configuration handed to the datapath
    typedef struct packed {
        logic                   mode;
        logic [LENGTH_BITS-1:0] frame_len;
        logic [BUCKET_BITS-1:0] buckets;
        logic                   pass;
        logic                   restart;
    } cfg_t;

    // Clamp the frame length to 1..MAX_FRAME
    function automatic logic [LENGTH_BITS-1:0] eff_length(input logic [LENGTH_BITS-1:0] raw);
        logic [LENGTH_BITS-1:0] n;
        n = raw;
        if (raw == '0)
            n = LENGTH_BITS'(1);
        else if (raw > LENGTH_BITS'(MAX_FRAME))
            n = LENGTH_BITS'(MAX_FRAME);
        return n;
    endfunction

    // Clamp the bucket count to 1..MAX_FRAME/2
    function automatic logic [BUCKET_BITS-1:0] eff_buckets(input logic [BUCKET_BITS-1:0] raw);
        logic [BUCKET_BITS-1:0] b;
        b = raw;
        if (raw == '0)
            b = BUCKET_BITS'(1);
        else if (raw > BUCKET_BITS'(MAX_BUCKETS))
            b = BUCKET_BITS'(MAX_BUCKETS);
        return b;
    endfunction

endpackage

FILE: hdl/m4bd_cfg.sv
// ----------------------------------------------------------------------------
// m4bd_cfg
// APB-style register file: mode, frame length and bucket count, with the
// clamped values, the pass-through decision and a registered restart pulse in
// the cycle after every write to a defined register.
// ----------------------------------------------------------------------------
module m4bd_cfg
    import m4bd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,
    output cfg_t                 cfg
);

    logic                       mode_reg, mode_next;
    logic [LENGTH_BITS-1:0]     frame_length_reg, frame_length_next;
    logic [BUCKET_BITS-1:0]     bucket_count_reg, bucket_count_next;
    logic [LENGTH_BITS-1:0]     eff_length_reg;
    logic [BUCKET_BITS-1:0]     eff_buckets_reg;
    logic                       restart_reg, restart_next;
    logic                       wr_en;
    logic [REG_INDEX_BITS-1:0]  reg_index;
    logic [BUCKET_BITS+1:0]     out_total;

    assign pready    = 1'b1;
    assign wr_en     = psel & penable & pwrite;
    assign reg_index = paddr[ADDR_BITS-1:2];

    // Decode the write transaction
    always_comb
    begin
        mode_next         = mode_reg;
        frame_length_next = frame_length_reg;
        bucket_count_next = bucket_count_reg;
        restart_next      = 1'b0;
        if (wr_en)
        begin
            case (reg_index)
                REG_MODE:
                begin
                    mode_next    = pwdata[0];
                    restart_next = 1'b1;
                end
                REG_FRAME_LENGTH:
                begin
                    frame_length_next = pwdata[LENGTH_BITS-1:0];
                    restart_next      = 1'b1;
                end
                REG_BUCKET_COUNT:
                begin
                    bucket_count_next = pwdata[BUCKET_BITS-1:0];
                    restart_next      = 1'b1;
                end
                default:
                begin
                    restart_next = 1'b0;
                end
            endcase
        end
    end

    // Hold raw and clamped register contents
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_MINMAX;
            frame_length_reg <= RESET_FRAME_LENGTH;
            bucket_count_reg <= RESET_BUCKET_COUNT;
            eff_length_reg   <= eff_length(RESET_FRAME_LENGTH);
            eff_buckets_reg  <= eff_buckets(RESET_BUCKET_COUNT);
            restart_reg      <= 1'b0;
        end
        else
        begin
            mode_reg         <= mode_next;
            frame_length_reg <= frame_length_next;
            bucket_count_reg <= bucket_count_next;
            eff_length_reg   <= eff_length(frame_length_next);
            eff_buckets_reg  <= eff_buckets(bucket_count_next);
            restart_reg      <= restart_next;
        end
    end

    // Read back the raw register contents
    always_comb
    begin
        case (reg_index)
            REG_MODE:         prdata = DATA_BITS'(mode_reg);
            REG_FRAME_LENGTH: prdata = DATA_BITS'(frame_length_reg);
            REG_BUCKET_COUNT: prdata = DATA_BITS'(bucket_count_reg);
            default:          prdata = '0;
        endcase
    end

    // Pass every index through when the output count reaches the frame length
    assign out_total = (mode_reg == MODE_M4) ? {eff_buckets_reg, 2'b00}
                                             : {1'b0, eff_buckets_reg, 1'b0};

    assign cfg.mode      = mode_reg;
    assign cfg.frame_len = eff_length_reg;
    assign cfg.buckets   = eff_buckets_reg;
    assign cfg.pass      = ({1'b0, out_total} >= {2'b00, eff_length_reg});
    assign cfg.restart   = restart_reg;

endmodule

FILE: hdl/minmax_m4_bucket_decimator.sv
// ----------------------------------------------------------------------------
// minmax_m4_bucket_decimator
// Index selection for plotting: picks first/last and min/max sample indices
// per bucket of a frame.
//
// Usage:
//   - Input channel (sample, in_valid, in_ready): one signed sample per
//     transaction; samples are numbered 0..frame_length-1 within a frame.
//   - Output channel (sample_index, bucket_end, frame_end, out_valid,
//     out_ready): one selected index per transaction. Min-max mode gives the
//     min and max indices of each bucket in ascending order; M4 mode gives
//     first, min/max pair and last. bucket_end marks the last index of a
//     bucket, frame_end the last of the frame.
//   - Configuration through the APB-style port; a write to a defined register
//     restarts the frame. Write only while the block is idle.
//   - A closing sample passes the input register and the result bundle before
//     its first index reaches the output register.
//   - Throughput: one sample per cycle while no closing sample waits. A sample
//     that closes a bucket loads a four-slot result bundle; the next closing
//     sample waits until the bundle has drained to its last slot, one index
//     leaving per cycle through the output register while out_ready allows.
//   - Reset clears the frame position and loads the default registers
//     (min-max, 1024 samples, 64 buckets).
//   - When out_ready is low and out_valid is high the output register and
//     bundle hold; samples that close no bucket are still taken until a
//     closing one reaches the working stage.
// ----------------------------------------------------------------------------
module minmax_m4_bucket_decimator
    import m4bd_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_BITS-1:0]          paddr,
    input  logic [DATA_BITS-1:0]          pwdata,
    output logic [DATA_BITS-1:0]          prdata,
    output logic                          pready,
    // sample channel
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          in_valid,
    output logic                          in_ready,
    // index channel
    output logic [INDEX_BITS-1:0]         sample_index,
    output logic                          bucket_end,
    output logic                          frame_end,
    output logic                          out_valid,
    input  logic                          out_ready
);

    cfg_t cfg;

    m4bd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input register
    logic                          s_valid_reg, s_valid_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg;

    // Frame tracking state
    logic [INDEX_BITS-1:0]         position_reg, position_next;
    logic [INDEX_BITS-1:0]         bucket_first_reg, bucket_first_next;
    logic signed [SAMPLE_BITS-1:0] low_value_reg, low_value_next;
    logic [INDEX_BITS-1:0]         low_position_reg, low_position_next;
    logic signed [SAMPLE_BITS-1:0] high_value_reg, high_value_next;
    logic [INDEX_BITS-1:0]         high_position_reg, high_position_next;
    logic [SCALED_BITS-1:0]        scaled_position_reg, scaled_position_next;
    logic [SCALED_BITS-1:0]        bucket_target_reg, bucket_target_next;

    // Result bundle and output register
    result_t                       slot_reg [MAX_RESULTS];
    result_t                       slot_next [MAX_RESULTS];
    logic [SLOT_CNT_BITS-1:0]      slot_cnt_reg, slot_cnt_next;
    result_t                       out_reg, out_next;
    logic                          out_valid_reg, out_valid_next;

    // Working stage signals
    result_t                       new_slot [MAX_RESULTS];
    logic [SLOT_CNT_BITS-1:0]      new_cnt;
    logic                          last;
    logic                          first;
    logic                          closes;
    logic [INDEX_BITS-1:0]         pair_lo, pair_hi;
    logic                          pop;
    logic                          bundle_free;
    logic                          fire;
    logic                          load;

    // Compare the sample against the held extremes and decide bucket closure
    always_comb
    begin
        last  = ({1'b0, position_reg} + LENGTH_BITS'(1)) >= cfg.frame_len;
        first = (position_reg == bucket_first_reg);

        low_value_next     = low_value_reg;
        low_position_next  = low_position_reg;
        high_value_next    = high_value_reg;
        high_position_next = high_position_reg;
        if (first)
        begin
            low_value_next     = sample_reg;
            low_position_next  = position_reg;
            high_value_next    = sample_reg;
            high_position_next = position_reg;
        end
        else
        begin
            if (sample_reg < low_value_reg)
            begin
                low_value_next    = sample_reg;
                low_position_next = position_reg;
            end
            if (sample_reg > high_value_reg)
            begin
                high_value_next    = sample_reg;
                high_position_next = position_reg;
            end
        end

        closes = last || (scaled_position_reg > bucket_target_reg);

        if (high_position_next < low_position_next)
        begin
            pair_lo = high_position_next;
            pair_hi = low_position_next;
        end
        else
        begin
            pair_lo = low_position_next;
            pair_hi = high_position_next;
        end
    end

    // Build the result bundle for this sample
    always_comb
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            new_slot[i] = '0;
        end
        new_cnt = '0;
        if (cfg.pass)
        begin
            new_slot[0] = '{index: position_reg, bucket_end: 1'b1, frame_end: last};
            new_cnt     = SLOT_CNT_BITS'(1);
        end
        else if (closes)
        begin
            if (cfg.mode == MODE_M4)
            begin
                new_slot[0] = '{index: bucket_first_reg, bucket_end: 1'b0, frame_end: 1'b0};
                new_slot[1] = '{index: pair_lo, bucket_end: 1'b0, frame_end: 1'b0};
                new_slot[2] = '{index: pair_hi, bucket_end: 1'b0, frame_end: 1'b0};
                new_slot[3] = '{index: position_reg, bucket_end: 1'b1, frame_end: last};
                new_cnt     = SLOT_CNT_BITS'(4);
            end
            else
            begin
                new_slot[0] = '{index: pair_lo, bucket_end: 1'b0, frame_end: 1'b0};
                new_slot[1] = '{index: pair_hi, bucket_end: 1'b1, frame_end: last};
                new_cnt     = SLOT_CNT_BITS'(2);
            end
        end
    end

    // Handshake: a sample with no results never waits for the bundle
    assign pop         = (slot_cnt_reg != '0) && (!out_valid_reg || out_ready);
    assign bundle_free = (slot_cnt_reg == '0)
                      || ((slot_cnt_reg == SLOT_CNT_BITS'(1)) && pop);
    assign fire        = s_valid_reg && (bundle_free || (new_cnt == '0));
    assign load        = fire && (new_cnt != '0);
    assign in_ready    = !s_valid_reg || fire;

    // Advance the frame state
    always_comb
    begin
        position_next        = position_reg;
        bucket_first_next    = bucket_first_reg;
        scaled_position_next = scaled_position_reg;
        bucket_target_next   = bucket_target_reg;
        if (fire && !cfg.pass)
        begin
            if (closes)
            begin
                bucket_target_next = bucket_target_reg
                                   + SCALED_BITS'(cfg.frame_len) - SCALED_BITS'(1);
                bucket_first_next  = position_reg + INDEX_BITS'(1);
            end
            scaled_position_next = scaled_position_reg + SCALED_BITS'(cfg.buckets);
        end
        if (fire)
        begin
            position_next = position_reg + INDEX_BITS'(1);
        end
    end

    // Hold the input register
    assign s_valid_next = (in_valid && in_ready) || (s_valid_reg && !fire);

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sample_reg <= sample;
        end
    end

    // Frame state registers; restart after a frame or a register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg         <= 1'b0;
            position_reg        <= '0;
            bucket_first_reg    <= '0;
            low_value_reg       <= '0;
            low_position_reg    <= '0;
            high_value_reg      <= '0;
            high_position_reg   <= '0;
            scaled_position_reg <= SCALED_BITS'(eff_buckets(RESET_BUCKET_COUNT));
            bucket_target_reg   <= SCALED_BITS'(eff_length(RESET_FRAME_LENGTH))
                                 - SCALED_BITS'(1);
        end
        else
        begin
            s_valid_reg <= s_valid_next;
            if (cfg.restart || (fire && last))
            begin
                position_reg        <= '0;
                bucket_first_reg    <= '0;
                low_value_reg       <= '0;
                low_position_reg    <= '0;
                high_value_reg      <= '0;
                high_position_reg   <= '0;
                scaled_position_reg <= SCALED_BITS'(cfg.buckets);
                bucket_target_reg   <= SCALED_BITS'(cfg.frame_len) - SCALED_BITS'(1);
            end
            else
            begin
                position_reg        <= position_next;
                bucket_first_reg    <= bucket_first_next;
                scaled_position_reg <= scaled_position_next;
                bucket_target_reg   <= bucket_target_next;
                if (fire && !cfg.pass)
                begin
                    low_value_reg     <= low_value_next;
                    low_position_reg  <= low_position_next;
                    high_value_reg    <= high_value_next;
                    high_position_reg <= high_position_next;
                end
            end
        end
    end

    // Load or drain the bundle, one index per cycle into the output register while it is not stalled
    always_comb
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            slot_next[i] = slot_reg[i];
        end
        slot_cnt_next = slot_cnt_reg;
        if (load)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                slot_next[i] = new_slot[i];
            end
            slot_cnt_next = new_cnt;
        end
        else if (pop)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                slot_next[i] = slot_reg[i + 1];
            end
            slot_cnt_next = slot_cnt_reg - SLOT_CNT_BITS'(1);
        end

        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_next       = slot_reg[0];
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            slot_reg[i] <= slot_next[i];
        end
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slot_cnt_reg  <= slot_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign sample_index = out_reg.index;
    assign bucket_end   = out_reg.bucket_end;
    assign frame_end    = out_reg.frame_end;
    assign out_valid    = out_valid_reg;

    // Checks on the bundle and frame tracking
    a_slot_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_cnt_reg <= SLOT_CNT_BITS'(MAX_RESULTS))
        else $error("result bundle count out of range");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> bundle_free)
        else $error("bundle overwritten before drained");

    a_position_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg.restart |-> ({1'b0, position_reg} < cfg.frame_len))
        else $error("frame position beyond frame length");

    a_frame_end_closes_bucket: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.frame_end) |-> out_reg.bucket_end)
        else $error("frame end without bucket end");

    a_load_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !cfg.restart) |=> (slot_cnt_reg != '0))
        else $error("loaded bundle is empty");

endmodule
